// ===== rtl/core/crs_pkg.sv =====
`timescale 1ns / 1ps

package crs_pkg;

  localparam int RATIO_W = 24;
  localparam int DEPTH_W = 16;
  localparam int PROD_W = DEPTH_W + RATIO_W;
  localparam int SQ_W = 2 * DEPTH_W;
  localparam int SEG_START_W = 20;
  localparam int SEG_LEN_W = 21;
  localparam int SUM_W = 36;
  localparam int SQ_SUM_W = 52;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 24'd65536;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFFFFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = 16'd16;
  localparam logic [SEG_LEN_W-1:0] LEN_FIELD_MAX = 21'h1FFFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_RATIO_SCALE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEL_THRESHOLD = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DUP_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HAS_BACKGROUND = 3'd4;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_DEL    = 2'd1,
    KIND_DUP    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_CHK,
    F_DIV,
    F_PUSH
  } fstate_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_scale;
    logic [RATIO_W-1:0] del_threshold;
    logic [RATIO_W-1:0] dup_threshold;
    logic [RATIO_W-1:0] step_threshold;
    logic               has_background;
  } cfg_t;

  // One classified bin as it travels from the front to the back.
  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [DEPTH_W-1:0] sample;
    logic [DEPTH_W-1:0] back;
    logic [SQ_W-1:0]    sample_sq;
    logic [SQ_W-1:0]    back_sq;
    logic               first_bin;
  } work_t;

endpackage

// ===== rtl/core/crs_if.sv =====
`timescale 1ns / 1ps

interface crs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_depth;
  logic [15:0] background_depth;
  logic        first_bin;

  modport source (output valid, output sample_depth, output background_depth,
                  output first_bin, input ready);
  modport sink (input valid, input sample_depth, input background_depth,
                input first_bin, output ready);
endinterface

interface crs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  seg_kind;
  logic [19:0] seg_start;
  logic [20:0] seg_length;
  logic [35:0] sample_sum;
  logic [51:0] sample_square_sum;
  logic [35:0] back_sum;
  logic [51:0] back_square_sum;

  modport source (output valid, output seg_kind, output seg_start, output seg_length,
                  output sample_sum, output sample_square_sum, output back_sum,
                  output back_square_sum, input ready);
  modport sink (input valid, input seg_kind, input seg_start, input seg_length,
                input sample_sum, input sample_square_sum, input back_sum,
                input back_square_sum, output ready);
endinterface

// ===== rtl/core/crs_queue.sv =====
`timescale 1ns / 1ps

module crs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  crs_pkg::work_t push_data,
  output logic          full,
  input  logic          pop,
  output crs_pkg::work_t pop_data,
  output logic          empty
);

  localparam int DEPTH = crs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crs_pkg::work_t     entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/crs_front.sv =====
`timescale 1ns / 1ps

module crs_front (
  input  logic            clk,
  input  logic            rst,
  crs_in_if.sink          in_ch,
  input  crs_pkg::cfg_t   cfg,
  output logic            push,
  output crs_pkg::work_t  push_data,
  input  logic            full
);

  localparam int DIV_STEPS = crs_pkg::RATIO_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  crs_pkg::fstate_t state;
  crs_pkg::fstate_t state_next;

  logic [crs_pkg::DEPTH_W-1:0] sample;
  logic [crs_pkg::DEPTH_W-1:0] back;
  logic                        first_bin;
  logic [crs_pkg::DEPTH_W-1:0] rem;
  logic [crs_pkg::RATIO_W-1:0] quo;
  logic [crs_pkg::SQ_W-1:0]    sample_sq;
  logic [crs_pkg::SQ_W-1:0]    back_sq;
  logic [CNT_W-1:0]            step_cnt;
  logic [crs_pkg::PROD_W-1:0]  prod;
  logic [crs_pkg::DEPTH_W:0]   trial;
  logic                        fits;
  logic                        accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign prod   = crs_pkg::PROD_W'(sample) * crs_pkg::PROD_W'(cfg.ratio_scale);
  assign trial  = {rem, quo[crs_pkg::RATIO_W-1]};
  assign fits   = (trial >= {1'b0, back});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crs_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    push        = 1'b0;
    case (state)
      crs_pkg::F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = crs_pkg::F_MUL;
        end
      end
      crs_pkg::F_MUL: begin
        state_next = crs_pkg::F_CHK;
      end
      crs_pkg::F_CHK: begin
        // A quotient that would not fit in 24 bits, or a zero divisor, saturates.
        state_next = (rem >= back) ? crs_pkg::F_PUSH : crs_pkg::F_DIV;
      end
      crs_pkg::F_DIV: begin
        if (step_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = crs_pkg::F_PUSH;
        end
      end
      crs_pkg::F_PUSH: begin
        push = 1'b1;
        if (!full) begin
          state_next = crs_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = crs_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      crs_pkg::F_IDLE: begin
        if (accept) begin
          sample    <= in_ch.sample_depth;
          back      <= cfg.has_background ? in_ch.background_depth : crs_pkg::DEPTH_ONE;
          first_bin <= in_ch.first_bin;
        end
      end
      crs_pkg::F_MUL: begin
        {rem, quo} <= prod;
        sample_sq  <= crs_pkg::SQ_W'(sample) * crs_pkg::SQ_W'(sample);
        back_sq    <= crs_pkg::SQ_W'(back) * crs_pkg::SQ_W'(back);
        step_cnt   <= '0;
      end
      crs_pkg::F_CHK: begin
        if (rem >= back) begin
          quo <= crs_pkg::RATIO_MAX;
        end
      end
      crs_pkg::F_DIV: begin
        // Restoring division, one quotient bit per cycle, MSB first.
        if (fits) begin
          rem <= crs_pkg::DEPTH_W'(trial - {1'b0, back});
        end else begin
          rem <= crs_pkg::DEPTH_W'(trial);
        end
        quo      <= {quo[crs_pkg::RATIO_W-2:0], fits};
        step_cnt <= step_cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_data.ratio     = quo;
    push_data.sample    = sample;
    push_data.back      = back;
    push_data.sample_sq = sample_sq;
    push_data.back_sq   = back_sq;
    push_data.first_bin = first_bin;
  end

`ifndef SYNTHESIS
  // The partial remainder must stay below the divisor through every step.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == crs_pkg::F_DIV) |-> (rem < back))
    else $error("divider remainder not below divisor");

  a_push_after_work: assert property (@(posedge clk) disable iff (rst)
    (state == crs_pkg::F_PUSH) |-> ($past(state) == crs_pkg::F_PUSH ||
      $past(state) == crs_pkg::F_DIV || $past(state) == crs_pkg::F_CHK))
    else $error("front pushed without finishing a ratio");
`endif

endmodule

// ===== rtl/core/crs_back.sv =====
`timescale 1ns / 1ps

module crs_back #(
  parameter int MAX_BINS = 1048576
) (
  input  logic            clk,
  input  logic            rst,
  input  crs_pkg::cfg_t   cfg,
  input  crs_pkg::work_t  work,
  input  logic            empty,
  output logic            pop,
  crs_out_if.source       out_ch
);

  localparam int IDX_W = $clog2(MAX_BINS);
  localparam int LEN_W = crs_pkg::SEG_LEN_W;
  localparam logic [LEN_W-1:0] LEN_CAP =
    (MAX_BINS < 2097151) ? LEN_W'(MAX_BINS) : crs_pkg::LEN_FIELD_MAX;
  localparam logic [crs_pkg::SUM_W-1:0] SUM_MAX = '1;
  localparam logic [crs_pkg::SQ_SUM_W-1:0] SQ_MAX = '1;

  crs_pkg::kind_t               mode;
  logic                         segment_open;
  logic [crs_pkg::RATIO_W-1:0]  prev_ratio;
  logic [IDX_W-1:0]             bin_index;
  logic [IDX_W-1:0]             start_index;
  logic [LEN_W-1:0]             run_length;
  logic [crs_pkg::SUM_W-1:0]    acc_sample;
  logic [crs_pkg::SQ_SUM_W-1:0] acc_sample_sq;
  logic [crs_pkg::SUM_W-1:0]    acc_back;
  logic [crs_pkg::SQ_SUM_W-1:0] acc_back_sq;

  logic                         out_valid;
  crs_pkg::kind_t               out_kind;
  logic [crs_pkg::SEG_START_W-1:0] out_start;
  logic [LEN_W-1:0]             out_length;
  logic [crs_pkg::SUM_W-1:0]    out_sample_sum;
  logic [crs_pkg::SQ_SUM_W-1:0] out_sample_sq;
  logic [crs_pkg::SUM_W-1:0]    out_back_sum;
  logic [crs_pkg::SQ_SUM_W-1:0] out_back_sq;

  logic [crs_pkg::RATIO_W-1:0]  prev_eff;
  logic                         open_eff;
  logic [IDX_W-1:0]             idx_eff;
  logic signed [25:0]           delta;
  logic signed [25:0]           step;
  logic                         is_low;
  logic                         is_high;
  crs_pkg::kind_t               init_kind;
  crs_pkg::kind_t               new_kind;
  logic                         emit;

  function automatic logic [crs_pkg::SUM_W-1:0] sat_sum(
    input logic [crs_pkg::SUM_W-1:0] a,
    input logic [crs_pkg::DEPTH_W-1:0] b
  );
    logic [crs_pkg::SUM_W:0] s;
    s = {1'b0, a} + (crs_pkg::SUM_W + 1)'(b);
    return s[crs_pkg::SUM_W] ? SUM_MAX : s[crs_pkg::SUM_W-1:0];
  endfunction

  function automatic logic [crs_pkg::SQ_SUM_W-1:0] sat_sq(
    input logic [crs_pkg::SQ_SUM_W-1:0] a,
    input logic [crs_pkg::SQ_W-1:0] b
  );
    logic [crs_pkg::SQ_SUM_W:0] s;
    s = {1'b0, a} + (crs_pkg::SQ_SUM_W + 1)'(b);
    return s[crs_pkg::SQ_SUM_W] ? SQ_MAX : s[crs_pkg::SQ_SUM_W-1:0];
  endfunction

  assign pop = !empty && (!out_valid || out_ch.ready);

  // A first-bin mark restarts the sequence before the bin is judged.
  assign prev_eff = work.first_bin ? crs_pkg::RATIO_ONE : prev_ratio;
  assign open_eff = work.first_bin ? 1'b0 : segment_open;
  assign idx_eff  = work.first_bin ? '0 : bin_index;

  assign delta   = $signed({2'b00, work.ratio}) - $signed({2'b00, prev_eff});
  assign step    = $signed({2'b00, cfg.step_threshold});
  assign is_low  = (work.ratio <= cfg.del_threshold);
  assign is_high = (work.ratio >= cfg.dup_threshold);

  always_comb begin
    if (is_low && (delta <= -step)) begin
      init_kind = crs_pkg::KIND_DEL;
    end else if (is_high && (delta >= step)) begin
      init_kind = crs_pkg::KIND_DUP;
    end else begin
      init_kind = crs_pkg::KIND_NORMAL;
    end
  end

  always_comb begin
    emit     = 1'b0;
    new_kind = init_kind;
    case (mode)
      crs_pkg::KIND_DEL: begin
        emit     = !is_low || (delta > step) || (delta < -step);
        new_kind = is_low ? crs_pkg::KIND_DEL : init_kind;
      end
      crs_pkg::KIND_DUP: begin
        emit     = !is_high || (delta >= step);
        new_kind = is_high ? crs_pkg::KIND_DUP : init_kind;
      end
      default: begin
        emit = (init_kind != crs_pkg::KIND_NORMAL);
      end
    endcase
    if (!open_eff) begin
      emit     = 1'b0;
      new_kind = init_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= crs_pkg::KIND_NORMAL;
      segment_open <= 1'b0;
      prev_ratio   <= crs_pkg::RATIO_ONE;
      bin_index    <= '0;
      start_index  <= '0;
      run_length   <= '0;
    end else if (pop) begin
      prev_ratio <= work.ratio;
      bin_index  <= (idx_eff == IDX_W'(MAX_BINS - 1)) ? '0 : idx_eff + 1'b1;
      if (!open_eff || emit) begin
        mode         <= new_kind;
        segment_open <= 1'b1;
        start_index  <= idx_eff;
        run_length   <= LEN_W'(1);
      end else if (run_length < LEN_CAP) begin
        run_length <= run_length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (!open_eff || emit) begin
        acc_sample    <= crs_pkg::SUM_W'(work.sample);
        acc_sample_sq <= crs_pkg::SQ_SUM_W'(work.sample_sq);
        acc_back      <= crs_pkg::SUM_W'(work.back);
        acc_back_sq   <= crs_pkg::SQ_SUM_W'(work.back_sq);
      end else begin
        acc_sample    <= sat_sum(acc_sample, work.sample);
        acc_sample_sq <= sat_sq(acc_sample_sq, work.sample_sq);
        acc_back      <= sat_sum(acc_back, work.back);
        acc_back_sq   <= sat_sq(acc_back_sq, work.back_sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_kind       <= mode;
      out_start      <= crs_pkg::SEG_START_W'(start_index);
      out_length     <= run_length;
      out_sample_sum <= acc_sample;
      out_sample_sq  <= acc_sample_sq;
      out_back_sum   <= acc_back;
      out_back_sq    <= acc_back_sq;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.seg_kind          = out_kind;
  assign out_ch.seg_start         = out_start;
  assign out_ch.seg_length        = out_length;
  assign out_ch.sample_sum        = out_sample_sum;
  assign out_ch.sample_square_sum = out_sample_sq;
  assign out_ch.back_sum          = out_back_sum;
  assign out_ch.back_square_sum   = out_back_sq;

`ifndef SYNTHESIS
  a_open_has_length: assert property (@(posedge clk) disable iff (rst)
    segment_open |-> (run_length != '0))
    else $error("open segment with zero length");

  a_first_bin_no_result: assert property (@(posedge clk) disable iff (rst)
    (pop && work.first_bin) |-> !emit)
    else $error("first bin closed a dropped segment");

  a_first_bin_index: assert property (@(posedge clk) disable iff (rst)
    (pop && work.first_bin) |=> (bin_index == IDX_W'(1)))
    else $error("bin index not restarted by first bin");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_length != '0))
    else $error("result with zero length");
`endif

endmodule

// ===== rtl/core/copy_ratio_segmenter_top.sv =====
`timescale 1ns / 1ps

// Channel   Role    Handshake            Payload
// in_ch     sink    valid/ready          sample_depth, background_depth, first_bin
// out_ch    source  valid/ready          seg_kind, seg_start, seg_length, four sums
// cfg       write   cfg_we, no wait      cfg_index, cfg_data
//
// The front takes one bin at a time and accepts the next only after pushing the last:
// accept, multiply, range check, 24 steps of the radix-2 ratio divider (skipped on
// saturation), and a push into a two-entry queue.
// The back judges and accumulates one queued bin per cycle while the queue is not empty and the output is not stalled.
// Synchronous reset restores the register defaults and empties the pipeline.
// A stalled output holds one result; the queue then fills and the front waits.

module copy_ratio_segmenter_top #(
  parameter int MAX_BINS = 1048576
) (
  input  logic                              clk,
  input  logic                              rst,
  crs_in_if.sink                            in_ch,
  crs_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [crs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  crs_pkg::cfg_t  cfg;
  crs_pkg::work_t push_data;
  crs_pkg::work_t pop_data;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio_scale    <= 24'd65536;
      cfg.del_threshold  <= 24'd49152;
      cfg.dup_threshold  <= 24'd81920;
      cfg.step_threshold <= 24'd16384;
      cfg.has_background <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        crs_pkg::REG_RATIO_SCALE:    cfg.ratio_scale    <= cfg_data;
        crs_pkg::REG_DEL_THRESHOLD:  cfg.del_threshold  <= cfg_data;
        crs_pkg::REG_DUP_THRESHOLD:  cfg.dup_threshold  <= cfg_data;
        crs_pkg::REG_STEP_THRESHOLD: cfg.step_threshold <= cfg_data;
        crs_pkg::REG_HAS_BACKGROUND: cfg.has_background <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  crs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  crs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  crs_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .work   (pop_data),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
